// ===== rtl/sector_to_page_map_window_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SECTOR_TO_PAGE_MAP_WINDOW_UNIT_ASSERT_SVH
`define SECTOR_TO_PAGE_MAP_WINDOW_UNIT_ASSERT_SVH

// same-cycle implication
`define STPMW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define STPMW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/stpmw_pkg.sv =====
package stpmw_pkg;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] sector;
      logic [7:0]  entry_pos;
      logic [31:0] page_value;
   } req_word_type;

   typedef struct packed {
      logic [31:0] result_value;
      logic [1:0]  status;
      logic        in_window;
   } rsp_word_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   localparam logic [2:0] KIND_LOOKUP     = 3'd0;
   localparam logic [2:0] KIND_STORE      = 3'd1;
   localparam logic [2:0] KIND_FIND       = 3'd2;
   localparam logic [2:0] KIND_LOAD       = 3'd3;
   localparam logic [2:0] KIND_INVALIDATE = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_WINDOW = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE   = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic REG_ENTRY_COUNT       = 1'b0;
   localparam logic REG_SECTORS_PER_ENTRY = 1'b1;

   localparam logic [8:0]  ENTRY_COUNT_RESET = 9'd256;
   localparam logic [15:0] SPE_RESET         = 16'd8;

endpackage

// ===== rtl/stpmw_div.sv =====
module stpmw_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   import stpmw_pkg::*;

   localparam logic [4:0] STEP_LAST = 5'd31;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  step_ff, step_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [16:0] trial;
   logic [16:0] diff;
   logic        ge;

   // restoring division, one quotient bit a cycle
   always_comb begin
      trial    = {rem_ff, quo_ff[31]};
      diff     = trial - {1'b0, dvs_ff};
      ge       = trial >= {1'b0, dvs_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[15:0] : trial[15:0];
         quo_in  = {quo_ff[30:0], ge};
         step_in = step_ff + 5'd1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/stpmw_table.sv =====
module stpmw_table #(
   parameter int unsigned MAX_ENTRIES = 256
) (
   input  logic                           clock,
   input  stpmw_pkg::mem_ctl_type         mem_ctl,
   input  logic [$clog2(MAX_ENTRIES)-1:0] mem_addr,
   input  logic [31:0]                    mem_wdata,
   output logic [31:0]                    mem_rdata
);
   import stpmw_pkg::*;

   logic [31:0] page_mem [MAX_ENTRIES];
   logic [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         page_mem[mem_addr] <= mem_wdata;
      end
      if (mem_ctl.rd_en) begin
         rdata_ff <= page_mem[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

// ===== rtl/stpmw_ctrl.sv =====
module stpmw_ctrl #(
   parameter int unsigned MAX_ENTRIES = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  stpmw_pkg::req_word_type        req_word,
   input  logic [8:0]                     entry_count,
   input  logic [15:0]                    sectors_per_entry,
   output logic                           res_valid,
   input  logic                           res_take,
   output stpmw_pkg::rsp_word_type        res_word,
   output stpmw_pkg::mem_ctl_type         mem_ctl,
   output logic [$clog2(MAX_ENTRIES)-1:0] mem_addr,
   output logic [31:0]                    mem_wdata,
   input  logic [31:0]                    mem_rdata,
   output logic                           div_start,
   output logic [31:0]                    div_dividend,
   output logic [15:0]                    div_divisor,
   input  logic                           div_done,
   input  logic [31:0]                    div_quotient
);
   import stpmw_pkg::*;

   localparam int unsigned ADDR_W = $clog2(MAX_ENTRIES);
   localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_READ  = 6'b001000,
      ST_SCAN  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   function automatic rsp_word_type make_rsp(logic [31:0] v, logic [1:0] s, logic w);
      rsp_word_type r;
      r.result_value = v;
      r.status       = s;
      r.in_window    = w;
      return r;
   endfunction

   state_type          state_ff, state_in;
   logic [31:0]        base_ff, base_in;
   logic [ADDR_W-1:0]  clr_idx_ff, clr_idx_in;
   logic               clr_reply_ff, clr_reply_in;
   logic               is_store_ff, is_store_in;
   logic [31:0]        page_ff, page_in;
   logic [CNT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [31:0]        scan_sector_ff, scan_sector_in;
   rsp_word_type       res_ff, res_in;

   logic [CNT_W-1:0]   used;
   logic [CNT_W-1:0]   scan_next;
   logic [15:0]        size;
   logic               loaded;
   logic               accept;

   always_comb begin
      if (32'(entry_count) > 32'(MAX_ENTRIES)) begin
         used = CNT_W'(MAX_ENTRIES);
      end else begin
         used = CNT_W'(entry_count);
      end
      size      = (sectors_per_entry == '0) ? 16'd1 : sectors_per_entry;
      loaded    = base_ff != ALL_ONES;
      scan_next = scan_idx_ff + CNT_W'(1);
   end

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid && req_ready;
   assign res_valid = state_ff == ST_DONE;
   assign res_word  = res_ff;

   always_comb begin
      state_in       = state_ff;
      base_in        = base_ff;
      clr_idx_in     = clr_idx_ff;
      clr_reply_in   = clr_reply_ff;
      is_store_in    = is_store_ff;
      page_in        = page_ff;
      scan_idx_in    = scan_idx_ff;
      scan_sector_in = scan_sector_ff;
      res_in         = res_ff;
      mem_ctl        = '0;
      mem_addr       = '0;
      mem_wdata      = ALL_ONES;
      div_start      = 1'b0;
      div_dividend   = req_word.sector - base_ff;
      div_divisor    = size;

      case (state_ff)
         ST_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            mem_addr      = clr_idx_ff;
            if (clr_idx_ff == ADDR_W'(MAX_ENTRIES - 1)) begin
               clr_reply_in = 1'b0;
               state_in     = clr_reply_ff ? ST_DONE : ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               page_in     = req_word.page_value;
               is_store_in = req_word.kind == KIND_STORE;
               case (req_word.kind)
                  KIND_LOOKUP, KIND_STORE: begin
                     if (!loaded) begin
                        res_in   = make_rsp(ALL_ONES, STATUS_NO_WINDOW, 1'b0);
                        state_in = ST_DONE;
                     end else if (req_word.sector < base_ff) begin
                        res_in   = make_rsp(ALL_ONES, STATUS_OUTSIDE, 1'b0);
                        state_in = ST_DONE;
                     end else begin
                        div_start = 1'b1;
                        state_in  = ST_DIV;
                     end
                  end
                  KIND_FIND: begin
                     if (!loaded) begin
                        res_in   = make_rsp(ALL_ONES, STATUS_NO_WINDOW, 1'b0);
                        state_in = ST_DONE;
                     end else if (used == '0) begin
                        res_in   = make_rsp(ALL_ONES, STATUS_NOT_FOUND, 1'b0);
                        state_in = ST_DONE;
                     end else begin
                        // first read goes out now, compare starts next cycle
                        mem_ctl.rd_en  = 1'b1;
                        mem_addr       = '0;
                        scan_idx_in    = '0;
                        scan_sector_in = base_ff;
                        state_in       = ST_SCAN;
                     end
                  end
                  KIND_LOAD: begin
                     base_in = req_word.sector;
                     if (32'(req_word.entry_pos) < 32'(used)) begin
                        mem_ctl.wr_en = 1'b1;
                        mem_addr      = ADDR_W'(req_word.entry_pos);
                        mem_wdata     = req_word.page_value;
                        res_in        = make_rsp('0, STATUS_OK, 1'b0);
                     end else begin
                        res_in = make_rsp(ALL_ONES, STATUS_OUTSIDE, 1'b0);
                     end
                     state_in = ST_DONE;
                  end
                  KIND_INVALIDATE: begin
                     clr_idx_in   = '0;
                     clr_reply_in = 1'b1;
                     res_in       = make_rsp('0, STATUS_OK, 1'b0);
                     state_in     = ST_CLEAR;
                  end
                  default: begin
                     res_in   = make_rsp('0, STATUS_OK, 1'b0);
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (div_quotient >= 32'(used)) begin
                  res_in   = make_rsp(ALL_ONES, STATUS_OUTSIDE, 1'b0);
                  state_in = ST_DONE;
               end else if (is_store_ff) begin
                  mem_ctl.wr_en = 1'b1;
                  mem_addr      = ADDR_W'(div_quotient);
                  mem_wdata     = page_ff;
                  res_in        = make_rsp('0, STATUS_OK, 1'b1);
                  state_in      = ST_DONE;
               end else begin
                  mem_ctl.rd_en = 1'b1;
                  mem_addr      = ADDR_W'(div_quotient);
                  state_in      = ST_READ;
               end
            end
         end
         ST_READ: begin
            res_in   = make_rsp(mem_rdata, STATUS_OK, 1'b1);
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            // mem_rdata holds entry scan_idx_ff; next entry is read alongside
            if (mem_rdata == page_ff) begin
               res_in   = make_rsp(scan_sector_ff, STATUS_OK, 1'b1);
               state_in = ST_DONE;
            end else if (scan_next == used) begin
               res_in   = make_rsp(ALL_ONES, STATUS_NOT_FOUND, 1'b0);
               state_in = ST_DONE;
            end else begin
               mem_ctl.rd_en  = 1'b1;
               mem_addr       = ADDR_W'(scan_next);
               scan_idx_in    = scan_next;
               scan_sector_in = scan_sector_ff + 32'(size);
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         base_ff      <= ALL_ONES;
         clr_idx_ff   <= '0;
         clr_reply_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         clr_idx_ff   <= clr_idx_in;
         clr_reply_ff <= clr_reply_in;
      end
   end

   always_ff @(posedge clock) begin
      is_store_ff    <= is_store_in;
      page_ff        <= page_in;
      scan_idx_ff    <= scan_idx_in;
      scan_sector_ff <= scan_sector_in;
      res_ff         <= res_in;
   end

endmodule

// ===== rtl/sector_to_page_map_window_unit.sv =====
// From accepted word to rsp_valid: load, unused kinds and early errors go straight to the
// result; store and lookup run the 32-step divider, then lookup does one table read; find
// scans to a hit or the last used entry; invalidate clears all (one table write a cycle).
// One word in flight: the next is taken the cycle after the result enters the output
// register, which holds it until rsp_ready.
// Synchronous reset, then a clearing pass over every table entry with req_ready low.
module sector_to_page_map_window_unit #(
   parameter int unsigned MAX_ENTRIES = 256
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  stpmw_pkg::req_word_type                 req_word,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output stpmw_pkg::rsp_word_type                 rsp_word,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [stpmw_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [31:0]                             pwdata,
   output logic [31:0]                             prdata,
   output logic                                    pready
);
   import stpmw_pkg::*;

   localparam int unsigned ADDR_W = $clog2(MAX_ENTRIES);

   logic [8:0]        entry_count_ff, entry_count_in;
   logic [15:0]       spe_ff, spe_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic              csr_wr;
   logic              csr_sel;
   logic              res_valid;
   logic              res_take;
   rsp_word_type      res_word;
   mem_ctl_type       mem_ctl;
   logic [ADDR_W-1:0] mem_addr;
   logic [31:0]       mem_wdata;
   logic [31:0]       mem_rdata;
   logic              div_start;
   logic [31:0]       div_dividend;
   logic [15:0]       div_divisor;
   logic              div_done;
   logic [31:0]       div_quotient;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_sel = paddr[2];

   always_comb begin
      entry_count_in = entry_count_ff;
      spe_in         = spe_ff;
      case (csr_sel)
         REG_ENTRY_COUNT: begin
            prdata = {23'd0, entry_count_ff};
            if (csr_wr) begin
               entry_count_in = pwdata[8:0];
            end
         end
         REG_SECTORS_PER_ENTRY: begin
            prdata = {16'd0, spe_ff};
            if (csr_wr) begin
               spe_in = pwdata[15:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // output register lets the core finish while the previous word waits
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res_word;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= ENTRY_COUNT_RESET;
         spe_ff         <= SPE_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         entry_count_ff <= entry_count_in;
         spe_ff         <= spe_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   stpmw_ctrl #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_word         (req_word),
      .entry_count      (entry_count_ff),
      .sectors_per_entry(spe_ff),
      .res_valid        (res_valid),
      .res_take         (res_take),
      .res_word         (res_word),
      .mem_ctl          (mem_ctl),
      .mem_addr         (mem_addr),
      .mem_wdata        (mem_wdata),
      .mem_rdata        (mem_rdata),
      .div_start        (div_start),
      .div_dividend     (div_dividend),
      .div_divisor      (div_divisor),
      .div_done         (div_done),
      .div_quotient     (div_quotient)
   );

   stpmw_table #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_table (
      .clock    (clock),
      .mem_ctl  (mem_ctl),
      .mem_addr (mem_addr),
      .mem_wdata(mem_wdata),
      .mem_rdata(mem_rdata)
   );

   stpmw_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_quotient)
   );

endmodule

// ===== rtl/stpmw_chk.sv =====
`include "sector_to_page_map_window_unit_assert.svh"

module stpmw_chk (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input stpmw_pkg::rsp_word_type rsp_word
);
   import stpmw_pkg::*;

   `STPMW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "rsp word changed while stalled")
   `STPMW_ASSERT_NOW(a_err_ones, clock, reset, rsp_valid && (rsp_word.status != STATUS_OK), (rsp_word.result_value == ALL_ONES) && !rsp_word.in_window, "error word not all ones")
   `STPMW_ASSERT_NOW(a_inwin_ok, clock, reset, rsp_valid && rsp_word.in_window, rsp_word.status == STATUS_OK, "in_window set with error status")
   `STPMW_ASSERT_NOW(a_clear_busy, clock, reset, $past(reset), !req_ready, "ready during clearing pass")

endmodule

bind sector_to_page_map_window_unit stpmw_chk u_chk (
   .clock    (clock),
   .reset    (reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_word (rsp_word)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import stpmw_pkg::*;

   localparam logic [2:0] KIND_SPARE5 = 3'd5;
   localparam logic [2:0] KIND_SPARE6 = 3'd6;
   localparam logic [2:0] KIND_SPARE7 = 3'd7;

   localparam logic [CSR_ADDR_W-1:0] ADDR_ENTRY_COUNT = {REG_ENTRY_COUNT, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPE         = {REG_SECTORS_PER_ENTRY, 2'b00};

   localparam int unsigned TABLE_DEPTH  = 256;
   localparam int unsigned NUM_PHASES   = 9;
   localparam int unsigned PHASE_WORDS  = 200;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned HOLD_AT_RSP  = 700;
   localparam int unsigned DRAIN_CYCLES = 300;
   localparam int unsigned STALL_LIMIT  = 4000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_word_type req_word;
   logic rsp_valid;
   logic rsp_ready;
   rsp_word_type rsp_word;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   sector_to_page_map_window_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // mirror of the map window
   logic [31:0] page_tbl [TABLE_DEPTH];
   logic [31:0] win_base;
   logic [8:0]  ent_count_cfg;
   logic [15:0] spe_cfg;

   rsp_word_type expected_rsp_q [$];
   logic [31:0]  page_pool [8];

   typedef struct {
      req_word_type w;
      bit           typed;
      rsp_word_type rsp;
   } dir_row_t;

   dir_row_t dir_rows [$];

   int unsigned ph_count [NUM_PHASES] = '{16, 1, 256, 0, 511, 300, 40, 256, 2};
   int unsigned ph_spe   [NUM_PHASES] = '{4, 1, 65535, 0, 3, 1, 100, 8, 65535};

   // expectation typed into the directed table, travels with the word
   bit           drv_typed;
   rsp_word_type drv_exp;

   bit          steady;
   bit          hold_done;
   int unsigned fail_count;
   int unsigned rsp_seen;
   int unsigned words_sent;
   int unsigned kind_seen [8];
   int unsigned idle_cycles;

   function automatic logic [31:0] used_entries();
      return (ent_count_cfg > 9'd256) ? 32'd256 : {23'd0, ent_count_cfg};
   endfunction

   function automatic logic [31:0] group_sectors();
      return (spe_cfg == 16'd0) ? 32'd1 : {16'd0, spe_cfg};
   endfunction

   function automatic rsp_word_type map_window_apply(req_word_type w);
      rsp_word_type r;
      logic [31:0] used;
      logic [31:0] grp;
      logic [31:0] idx;
      logic [31:0] k;
      bit hit;
      r = '{32'd0, STATUS_OK, 1'b0};
      used = used_entries();
      grp = group_sectors();
      case (w.kind)
         KIND_LOOKUP, KIND_STORE: begin
            if (win_base == ALL_ONES) begin
               r = '{ALL_ONES, STATUS_NO_WINDOW, 1'b0};
            end else if (w.sector < win_base) begin
               r = '{ALL_ONES, STATUS_OUTSIDE, 1'b0};
            end else begin
               idx = (w.sector - win_base) / grp;
               if (idx >= used) begin
                  r = '{ALL_ONES, STATUS_OUTSIDE, 1'b0};
               end else if (w.kind == KIND_LOOKUP) begin
                  r = '{page_tbl[idx[7:0]], STATUS_OK, 1'b1};
               end else begin
                  page_tbl[idx[7:0]] = w.page_value;
                  r = '{32'd0, STATUS_OK, 1'b1};
               end
            end
         end
         KIND_FIND: begin
            if (win_base == ALL_ONES) begin
               r = '{ALL_ONES, STATUS_NO_WINDOW, 1'b0};
            end else begin
               r = '{ALL_ONES, STATUS_NOT_FOUND, 1'b0};
               hit = 1'b0;
               for (int i = 0; i < int'(used) && !hit; i++) begin
                  if (page_tbl[i] == w.page_value) begin
                     k = i;
                     r = '{k * grp + win_base, STATUS_OK, 1'b1};
                     hit = 1'b1;
                  end
               end
            end
         end
         KIND_LOAD: begin
            win_base = w.sector;
            if ({24'd0, w.entry_pos} < used) begin
               page_tbl[w.entry_pos] = w.page_value;
               r = '{32'd0, STATUS_OK, 1'b0};
            end else begin
               r = '{ALL_ONES, STATUS_OUTSIDE, 1'b0};
            end
         end
         KIND_INVALIDATE: begin
            for (int i = 0; i < TABLE_DEPTH; i++) page_tbl[i] = ALL_ONES;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [31:0] pick_page();
      int unsigned r;
      int unsigned slot;
      r = $urandom_range(0, 99);
      slot = $urandom_range(0, 7);
      if (r < 60) return page_pool[slot];
      if (r < 70) return ALL_ONES;
      if (r < 75) return 32'd0;
      page_pool[slot] = $urandom;
      return page_pool[slot];
   endfunction

   // mostly well-formed traffic aimed into the current window, some noise
   function automatic req_word_type next_map_word();
      req_word_type w;
      int unsigned r;
      logic [31:0] used;
      logic [31:0] span;
      used = used_entries();
      span = used * group_sectors();
      r = $urandom_range(0, 99);
      if (r >= 93) begin
         w.kind = 3'($urandom_range(0, 7));
         w.sector = $urandom;
         w.entry_pos = 8'($urandom);
         w.page_value = $urandom;
         return w;
      end
      if (r < 30)      w.kind = KIND_LOOKUP;
      else if (r < 55) w.kind = KIND_STORE;
      else if (r < 70) w.kind = KIND_FIND;
      else if (r < 88) w.kind = KIND_LOAD;
      else if (r < 90) w.kind = KIND_INVALIDATE;
      else             w.kind = 3'($urandom_range(5, 7));
      r = $urandom_range(0, 99);
      if (w.kind == KIND_LOAD) begin
         if (r < 40 && win_base != ALL_ONES) w.sector = win_base;
         else if (r < 70) w.sector = $urandom_range(0, 5000);
         else if (r < 80) w.sector = ALL_ONES - $urandom_range(1, 20000000);
         else if (r < 82) w.sector = ALL_ONES;
         else             w.sector = $urandom;
      end else if (r < 70 && span != 0 && win_base != ALL_ONES) begin
         w.sector = win_base + $urandom_range(0, span - 1);
      end else if (r < 80) begin
         case ($urandom_range(0, 2))
            0:       w.sector = win_base - 32'd1;
            1:       w.sector = win_base + span - 32'd1;
            default: w.sector = win_base + span;
         endcase
      end else if (r < 85) begin
         w.sector = $urandom_range(0, 1) ? ALL_ONES : 32'd0;
      end else begin
         w.sector = $urandom;
      end
      if ($urandom_range(0, 99) < 75 && used != 0)
         w.entry_pos = 8'($urandom_range(0, (used > 256) ? 255 : used - 1));
      else
         w.entry_pos = 8'($urandom);
      w.page_value = pick_page();
      return w;
   endfunction

   function automatic void add_dir(logic [2:0] k, logic [31:0] s, logic [7:0] p,
                                   logic [31:0] pg, bit t, logic [31:0] v,
                                   logic [1:0] st, logic iw);
      dir_row_t row;
      row.w = '{k, s, p, pg};
      row.typed = t;
      row.rsp = '{v, st, iw};
      dir_rows.push_back(row);
   endfunction

   task automatic send_word(req_word_type w, bit typed, rsp_word_type ex);
      int unsigned g;
      g = pick_gap();
      if (g > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= w;
      drv_typed <= typed;
      drv_exp   <= ex;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic finish_phase();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_ENTRY_COUNT) ent_count_cfg = data[8:0];
      else                          spe_cfg = data[15:0];
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // response checker and prediction at the input handshake
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response word with none expected: result_value %h status %0d",
                      rsp_word.result_value, rsp_word.status);
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               rsp_seen++;
               if (rsp_word.result_value !== want.result_value) begin
                  $error("result_value: expected %h, got %h",
                         want.result_value, rsp_word.result_value);
                  fail_count++;
               end
               if (rsp_word.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_word.status);
                  fail_count++;
               end
               if (rsp_word.in_window !== want.in_window) begin
                  $error("in_window: expected %0d, got %0d",
                         want.in_window, rsp_word.in_window);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            want = map_window_apply(req_word);
            if (drv_typed) want = drv_exp;
            expected_rsp_q.push_back(want);
            kind_seen[req_word.kind]++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", idle_cycles);
         $display("** sector_to_page_map_window_unit: FAILED **");
         $finish;
      end
   end

   // receiver: random back-pressure, plus one long hold-off to fill the block
   initial begin
      int unsigned g;
      rsp_ready = 1'b0;
      hold_done = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (!hold_done && rsp_seen >= HOLD_AT_RSP) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            g = pick_gap();
            if (g == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               repeat (g - 1) @(negedge clock);
            end
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      drv_typed = 1'b0;
      drv_exp   = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      steady    = 1'b0;
      fail_count  = 0;
      rsp_seen    = 0;
      words_sent  = 0;
      idle_cycles = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) page_tbl[i] = ALL_ONES;
      win_base      = ALL_ONES;
      ent_count_cfg = ENTRY_COUNT_RESET;
      spe_cfg       = SPE_RESET;
      foreach (page_pool[i]) page_pool[i] = $urandom;

      // directed rows under reset settings: 256 entries of 8 sectors
      add_dir(KIND_LOOKUP, 32'd0, 8'd0, 32'd0, 1'b1, ALL_ONES, STATUS_NO_WINDOW, 1'b0);
      add_dir(KIND_STORE, 32'h10, 8'd0, 32'd7, 1'b1, ALL_ONES, STATUS_NO_WINDOW, 1'b0);
      add_dir(KIND_FIND, 32'd0, 8'd0, 32'd0, 1'b1, ALL_ONES, STATUS_NO_WINDOW, 1'b0);
      add_dir(KIND_SPARE7, ALL_ONES, 8'hFF, ALL_ONES, 1'b1, 32'd0, STATUS_OK, 1'b0);
      // load at base all ones keeps the window unloaded
      add_dir(KIND_LOAD, ALL_ONES, 8'd0, 32'd5, 1'b1, 32'd0, STATUS_OK, 1'b0);
      add_dir(KIND_LOOKUP, ALL_ONES, 8'd0, 32'd0, 1'b1, ALL_ONES, STATUS_NO_WINDOW, 1'b0);
      add_dir(KIND_LOAD, 32'd1000, 8'd0, 32'd0, 1'b1, 32'd0, STATUS_OK, 1'b0);
      add_dir(KIND_LOAD, 32'd1000, 8'd255, 32'hFFFF_FFFE, 1'b1, 32'd0, STATUS_OK, 1'b0);
      add_dir(KIND_LOOKUP, 32'd999, 8'd0, 32'd0, 1'b1, ALL_ONES, STATUS_OUTSIDE, 1'b0);
      add_dir(KIND_LOOKUP, 32'd1000, 8'd0, 32'd0, 1'b1, 32'd0, STATUS_OK, 1'b1);
      add_dir(KIND_LOOKUP, 32'd3047, 8'd0, 32'd0, 1'b0, 32'd0, STATUS_OK, 1'b0);
      add_dir(KIND_LOOKUP, 32'd3048, 8'd0, 32'd0, 1'b1, ALL_ONES, STATUS_OUTSIDE, 1'b0);
      add_dir(KIND_LOOKUP, 32'd1008, 8'd0, 32'd0, 1'b0, 32'd0, STATUS_OK, 1'b0);
      add_dir(KIND_STORE, 32'd3048, 8'd0, 32'd1, 1'b1, ALL_ONES, STATUS_OUTSIDE, 1'b0);
      add_dir(KIND_STORE, 32'd1016, 8'd0, 32'h1234_5678, 1'b1, 32'd0, STATUS_OK, 1'b1);
      add_dir(KIND_FIND, 32'd0, 8'd0, 32'h1234_5678, 1'b0, 32'd0, STATUS_OK, 1'b0);
      add_dir(KIND_FIND, 32'd0, 8'd0, ALL_ONES, 1'b0, 32'd0, STATUS_OK, 1'b0);
      add_dir(KIND_FIND, 32'd0, 8'd0, 32'h5555_5555, 1'b1, ALL_ONES, STATUS_NOT_FOUND, 1'b0);
      add_dir(KIND_LOOKUP, ALL_ONES, 8'd0, 32'd0, 1'b1, ALL_ONES, STATUS_OUTSIDE, 1'b0);
      add_dir(KIND_SPARE5, 32'd0, 8'd0, 32'd0, 1'b1, 32'd0, STATUS_OK, 1'b0);
      add_dir(KIND_SPARE6, 32'h5A5A_A5A5, 8'h55, 32'd9, 1'b1, 32'd0, STATUS_OK, 1'b0);
      add_dir(KIND_INVALIDATE, 32'd0, 8'd0, 32'd0, 1'b1, 32'd0, STATUS_OK, 1'b0);
      add_dir(KIND_LOOKUP, 32'd1000, 8'd0, 32'd0, 1'b0, 32'd0, STATUS_OK, 1'b0);
      add_dir(KIND_FIND, 32'd0, 8'd0, 32'd0, 1'b1, ALL_ONES, STATUS_NOT_FOUND, 1'b0);
      add_dir(KIND_LOAD, 32'd0, 8'hAA, 32'hA5A5_5A5A, 1'b1, 32'd0, STATUS_OK, 1'b0);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].rsp);
      finish_phase();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         steady = (ph == 7);
         csr_write(ADDR_ENTRY_COUNT, ph_count[ph]);
         csr_write(ADDR_SPE, ph_spe[ph]);
         repeat (PHASE_WORDS) send_word(next_map_word(), 1'b0, '0);
         finish_phase();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsp_q.size() != 0) begin
         $error("%0d response words never arrived", expected_rsp_q.size());
         fail_count++;
      end

      $display("Ran %0d words over %0d register settings: %0d lookups, %0d stores, %0d finds,",
               words_sent, NUM_PHASES + 1, kind_seen[KIND_LOOKUP], kind_seen[KIND_STORE],
               kind_seen[KIND_FIND]);
      $display("%0d loads, %0d invalidates, %0d spare kinds; %0d responses checked.",
               kind_seen[KIND_LOAD], kind_seen[KIND_INVALIDATE],
               kind_seen[KIND_SPARE5] + kind_seen[KIND_SPARE6] + kind_seen[KIND_SPARE7],
               rsp_seen);
      if (fail_count == 0)
         $display("** sector_to_page_map_window_unit: PASSED **");
      else
         $display("** sector_to_page_map_window_unit: FAILED **");
      $finish;
   end

endmodule
